// ----- rtl/gdcr_pkg.sv -----
// ----------------------------------------------------------------------------
// gdcr_pkg: shared types and constants for the grid DDA column raycaster
// Screen and map geometry, fixed-point widths, queue item and back-end states.
// ----------------------------------------------------------------------------
package gdcr_pkg;

  localparam int SCREEN_W  = 1024;
  localparam int SCREEN_H  = 768;
  localparam int HALF_H    = SCREEN_H / 2;
  localparam int MAP_SIDE  = 64;
  localparam int MAP_BITS  = 6;
  localparam int ADDR_W    = 2 * MAP_BITS;
  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int CLR_W     = ADDR_W + 1;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int RAY_W   = 18;
  localparam int DELTA_W = 33;
  localparam int DIST_W  = 53;
  localparam int QUO_W   = 36;
  localparam int CNT_W   = 6;
  localparam int POS_W   = 16;
  localparam int FRAC_W  = 10;
  localparam int CELL_W  = 8;

  localparam logic [15:0] SHADE_X = 16'd65535;
  localparam logic [15:0] SHADE_Y = 16'd33000;

  localparam logic [DELTA_W-1:0] DELTA_INF = DELTA_W'(64'd1 << 32);
  localparam logic [QUO_W-1:0]   DIV_ONE   = QUO_W'(64'd1 << 30);
  localparam logic [QUO_W-1:0]   LINE_NUM  = QUO_W'(64'(SCREEN_H) << 26);

  localparam logic [15:0] POS_X_RST   = 16'd0;
  localparam logic [15:0] POS_Y_RST   = 16'd0;
  localparam logic [15:0] DIR_X_RST   = 16'hC000;
  localparam logic [15:0] DIR_Y_RST   = 16'd0;
  localparam logic [15:0] PLANE_X_RST = 16'd0;
  localparam logic [15:0] PLANE_Y_RST = 16'd10813;

  typedef enum logic [2:0] {
    CFG_POS_X,
    CFG_POS_Y,
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_PLANE_X,
    CFG_PLANE_Y
  } cfg_reg_t;

  typedef struct packed {
    logic                    is_cast;
    logic [COL_W-1:0]        col;
    logic [ADDR_W-1:0]       addr;
    logic                    wall;
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  num;
    logic [DIST_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XS,
    ST_XW,
    ST_YS,
    ST_YW,
    ST_INIT,
    ST_STEP,
    ST_CHECK,
    ST_LS,
    ST_LW,
    ST_RES
  } back_state_t;

  // ray = dir + plane * num / SCREEN_W, quotient truncated toward zero
  function automatic logic signed [RAY_W-1:0] ray_comp(
    input logic signed [15:0] dir,
    input logic signed [15:0] plane,
    input logic signed [11:0] num
  );
    logic signed [27:0] t;
    logic signed [27:0] tb;
    t  = 28'(plane) * 28'(num);
    tb = t[27] ? t + 28'sd1023 : t;
    return RAY_W'(dir) + RAY_W'(tb >>> 10);
  endfunction

endpackage

// ----- rtl/gdcr_ram.sv -----
// ----------------------------------------------------------------------------
// gdcr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gdcr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gdcr_div.sv -----
// ----------------------------------------------------------------------------
// gdcr_div: shared restoring divider
// One quotient bit per cycle; done pulses in the same cycle as the last quotient bit.
// ----------------------------------------------------------------------------
module gdcr_div (
  input  logic                clk,
  input  logic                rst,
  input  gdcr_pkg::div_req_t  req,
  output gdcr_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [gdcr_pkg::CNT_W-1:0]    cnt;
  logic [gdcr_pkg::DIST_W-1:0]   rem;
  logic [gdcr_pkg::DIST_W-1:0]   den;
  logic [gdcr_pkg::QUO_W-1:0]    q;
  logic [gdcr_pkg::DIST_W:0]     rem_sh;
  logic                          ge;

  assign rem_sh = {rem, q[gdcr_pkg::QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == gdcr_pkg::CNT_W'(gdcr_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.den;
      q   <= req.num;
    end else if (busy) begin
      rem <= ge ? gdcr_pkg::DIST_W'(rem_sh - {1'b0, den}) : rem_sh[gdcr_pkg::DIST_W-1:0];
      q   <= {q[gdcr_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = q;

endmodule

// ----- rtl/gdcr_front.sv -----
// ----------------------------------------------------------------------------
// gdcr_front: input stage
// Takes items, drops those out of range, forms the ray of a cast column.
// ----------------------------------------------------------------------------
module gdcr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [9:0]            column,
  input  logic [5:0]            cell_x,
  input  logic [5:0]            cell_y,
  input  logic                  wall,
  input  logic signed [15:0]    dir_x,
  input  logic signed [15:0]    dir_y,
  input  logic signed [15:0]    plane_x,
  input  logic signed [15:0]    plane_y,
  output logic                  push_valid,
  input  logic                  push_ready,
  output gdcr_pkg::item_t       push_item
);

  logic               f_valid;
  logic               f_valid_next;
  gdcr_pkg::item_t    f_item;
  gdcr_pkg::item_t    f_item_next;
  logic               take;
  logic               keep;
  logic signed [11:0] num;

  assign in_ready   = en && (!f_valid || push_ready);
  assign take       = in_valid && in_ready;
  assign push_valid = f_valid;
  assign push_item  = f_item;

  always_comb begin
    num  = $signed({2'b00, column}) * 12'sd2 - 12'sd1024;
    keep = mode ? (32'(column) < gdcr_pkg::SCREEN_W)
                : (32'(cell_x) < gdcr_pkg::MAP_SIDE && 32'(cell_y) < gdcr_pkg::MAP_SIDE);
    f_item_next.is_cast = mode;
    f_item_next.col     = column;
    f_item_next.addr    = {cell_x, cell_y};
    f_item_next.wall    = wall;
    f_item_next.rx      = gdcr_pkg::ray_comp(dir_x, plane_x, num);
    f_item_next.ry      = gdcr_pkg::ray_comp(dir_y, plane_y, num);
    if (take) begin
      f_valid_next = keep;
    end else if (push_ready) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_item <= f_item_next;
    end
  end

endmodule

// ----- rtl/gdcr_fifo.sv -----
// ----------------------------------------------------------------------------
// gdcr_fifo: two-entry item queue between front and back
// ----------------------------------------------------------------------------
module gdcr_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  gdcr_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output gdcr_pkg::item_t  pop_item
);

  gdcr_pkg::item_t ent [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = cnt != 2'd2;
  assign pop_valid  = cnt != 2'd0;
  assign pop_item   = ent[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/gdcr_back.sv -----
// ----------------------------------------------------------------------------
// gdcr_back: map owner and column caster
// Clears the map after reset, applies map writes, runs divisions, DDA walk
// and line span, and holds the result register.
// ----------------------------------------------------------------------------
module gdcr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  gdcr_pkg::item_t  pop_item,
  input  logic [15:0]      pos_x,
  input  logic [15:0]      pos_y,
  output logic             clr_done,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [9:0]       column_out,
  output logic [9:0]       draw_start,
  output logic [9:0]       draw_end,
  output logic             side,
  output logic [15:0]      shade,
  output logic             edge_hit
);

  gdcr_pkg::back_state_t state;
  gdcr_pkg::back_state_t state_next;

  logic [gdcr_pkg::CLR_W-1:0]         clr_addr;
  gdcr_pkg::item_t                    cur;
  logic [gdcr_pkg::DELTA_W-1:0]       dx;
  logic [gdcr_pkg::DELTA_W-1:0]       dy;
  logic [gdcr_pkg::DIST_W-1:0]        sx;
  logic [gdcr_pkg::DIST_W-1:0]        sy;
  logic [gdcr_pkg::DIST_W-1:0]        last;
  logic signed [gdcr_pkg::CELL_W-1:0] mx;
  logic signed [gdcr_pkg::CELL_W-1:0] my;
  logic                               hit_side;
  logic                               hit_edge;
  logic [gdcr_pkg::QUO_W-1:0]         lh;

  logic                               ram_we;
  logic [gdcr_pkg::ADDR_W-1:0]        ram_waddr;
  logic                               ram_wdata;
  logic [gdcr_pkg::ADDR_W-1:0]        ram_raddr;
  logic                               ram_rdata;
  gdcr_pkg::div_req_t                 dreq;
  gdcr_pkg::div_rsp_t                 drsp;

  logic                               go_x;
  logic signed [gdcr_pkg::CELL_W-1:0] mx_n;
  logic signed [gdcr_pkg::CELL_W-1:0] my_n;
  logic                               off_map;
  logic [gdcr_pkg::RAY_W-1:0]         abs_rx;
  logic [gdcr_pkg::RAY_W-1:0]         abs_ry;
  logic [gdcr_pkg::FRAC_W:0]          frac_x;
  logic [gdcr_pkg::FRAC_W:0]          frac_y;
  logic [gdcr_pkg::QUO_W-2:0]         half_lh;
  logic                               out_free;

  gdcr_ram #(
    .WIDTH (1),
    .DEPTH (gdcr_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdcr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_comb begin
    abs_rx  = cur.rx[gdcr_pkg::RAY_W-1] ? gdcr_pkg::RAY_W'(-cur.rx) : gdcr_pkg::RAY_W'(cur.rx);
    abs_ry  = cur.ry[gdcr_pkg::RAY_W-1] ? gdcr_pkg::RAY_W'(-cur.ry) : gdcr_pkg::RAY_W'(cur.ry);
    frac_x  = cur.rx[gdcr_pkg::RAY_W-1] ? {1'b0, pos_x[gdcr_pkg::FRAC_W-1:0]}
                                        : 11'd1024 - {1'b0, pos_x[gdcr_pkg::FRAC_W-1:0]};
    frac_y  = cur.ry[gdcr_pkg::RAY_W-1] ? {1'b0, pos_y[gdcr_pkg::FRAC_W-1:0]}
                                        : 11'd1024 - {1'b0, pos_y[gdcr_pkg::FRAC_W-1:0]};
    go_x    = sx < sy;
    mx_n    = mx;
    my_n    = my;
    if (go_x) begin
      mx_n = cur.rx[gdcr_pkg::RAY_W-1] ? mx - 8'sd1 : mx + 8'sd1;
    end else begin
      my_n = cur.ry[gdcr_pkg::RAY_W-1] ? my - 8'sd1 : my + 8'sd1;
    end
    off_map = mx_n < 8'sd0 || mx_n >= gdcr_pkg::CELL_W'(gdcr_pkg::MAP_SIDE)
           || my_n < 8'sd0 || my_n >= gdcr_pkg::CELL_W'(gdcr_pkg::MAP_SIDE);
    half_lh  = lh[gdcr_pkg::QUO_W-1:1];
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gdcr_pkg::ST_CLEAR: begin
        if (clr_addr == gdcr_pkg::CLR_W'(gdcr_pkg::MAP_DEPTH - 1)) begin
          state_next = gdcr_pkg::ST_IDLE;
        end
      end
      gdcr_pkg::ST_IDLE: begin
        if (pop_valid && pop_item.is_cast) begin
          state_next = gdcr_pkg::ST_XS;
        end
      end
      gdcr_pkg::ST_XS: state_next = (cur.rx == '0) ? gdcr_pkg::ST_YS : gdcr_pkg::ST_XW;
      gdcr_pkg::ST_XW: begin
        if (drsp.done) begin
          state_next = gdcr_pkg::ST_YS;
        end
      end
      gdcr_pkg::ST_YS: state_next = (cur.ry == '0) ? gdcr_pkg::ST_INIT : gdcr_pkg::ST_YW;
      gdcr_pkg::ST_YW: begin
        if (drsp.done) begin
          state_next = gdcr_pkg::ST_INIT;
        end
      end
      gdcr_pkg::ST_INIT:  state_next = gdcr_pkg::ST_STEP;
      gdcr_pkg::ST_STEP:  state_next = off_map ? gdcr_pkg::ST_LS : gdcr_pkg::ST_CHECK;
      gdcr_pkg::ST_CHECK: state_next = ram_rdata ? gdcr_pkg::ST_LS : gdcr_pkg::ST_STEP;
      gdcr_pkg::ST_LS:    state_next = (last == '0) ? gdcr_pkg::ST_RES : gdcr_pkg::ST_LW;
      gdcr_pkg::ST_LW: begin
        if (drsp.done) begin
          state_next = gdcr_pkg::ST_RES;
        end
      end
      gdcr_pkg::ST_RES: begin
        if (out_free) begin
          state_next = gdcr_pkg::ST_IDLE;
        end
      end
      default: state_next = gdcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = state == gdcr_pkg::ST_IDLE;
    clr_done  = state != gdcr_pkg::ST_CLEAR;
    ram_we    = 1'b0;
    ram_waddr = pop_item.addr;
    ram_wdata = pop_item.wall;
    ram_raddr = {mx_n[gdcr_pkg::MAP_BITS-1:0], my_n[gdcr_pkg::MAP_BITS-1:0]};
    dreq      = '0;
    unique case (state)
      gdcr_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr[gdcr_pkg::ADDR_W-1:0];
        ram_wdata = 1'b0;
      end
      gdcr_pkg::ST_IDLE: ram_we = pop_valid && !pop_item.is_cast;
      gdcr_pkg::ST_XS: begin
        dreq.start = cur.rx != '0;
        dreq.num   = gdcr_pkg::DIV_ONE;
        dreq.den   = gdcr_pkg::DIST_W'(abs_rx);
      end
      gdcr_pkg::ST_YS: begin
        dreq.start = cur.ry != '0;
        dreq.num   = gdcr_pkg::DIV_ONE;
        dreq.den   = gdcr_pkg::DIST_W'(abs_ry);
      end
      gdcr_pkg::ST_LS: begin
        dreq.start = last != '0;
        dreq.num   = gdcr_pkg::LINE_NUM;
        dreq.den   = last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdcr_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gdcr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == gdcr_pkg::ST_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gdcr_pkg::ST_IDLE: begin
        cur      <= pop_item;
        hit_edge <= 1'b0;
      end
      gdcr_pkg::ST_XS: dx <= gdcr_pkg::DELTA_INF;
      gdcr_pkg::ST_XW: dx <= drsp.quo[gdcr_pkg::DELTA_W-1:0];
      gdcr_pkg::ST_YS: dy <= gdcr_pkg::DELTA_INF;
      gdcr_pkg::ST_YW: dy <= drsp.quo[gdcr_pkg::DELTA_W-1:0];
      gdcr_pkg::ST_INIT: begin
        mx <= gdcr_pkg::CELL_W'(pos_x[gdcr_pkg::POS_W-1:gdcr_pkg::FRAC_W]);
        my <= gdcr_pkg::CELL_W'(pos_y[gdcr_pkg::POS_W-1:gdcr_pkg::FRAC_W]);
        sx <= gdcr_pkg::DIST_W'(44'(frac_x) * 44'(dx));
        sy <= gdcr_pkg::DIST_W'(44'(frac_y) * 44'(dy));
      end
      gdcr_pkg::ST_STEP: begin
        mx       <= mx_n;
        my       <= my_n;
        hit_side <= !go_x;
        hit_edge <= off_map;
        if (go_x) begin
          last <= sx;
          sx   <= sx + gdcr_pkg::DIST_W'({dx, 10'b0});
        end else begin
          last <= sy;
          sy   <= sy + gdcr_pkg::DIST_W'({dy, 10'b0});
        end
      end
      gdcr_pkg::ST_LS: lh <= gdcr_pkg::QUO_W'(gdcr_pkg::SCREEN_H);
      gdcr_pkg::ST_LW: lh <= drsp.quo;
      gdcr_pkg::ST_RES: begin
        if (out_free) begin
          column_out <= cur.col;
          side       <= hit_side;
          shade      <= hit_side ? gdcr_pkg::SHADE_Y : gdcr_pkg::SHADE_X;
          edge_hit   <= hit_edge;
          if (half_lh >= (gdcr_pkg::QUO_W - 1)'(gdcr_pkg::HALF_H)) begin
            draw_start <= '0;
            draw_end   <= gdcr_pkg::ROW_W'(gdcr_pkg::SCREEN_H - 1);
          end else begin
            draw_start <= gdcr_pkg::ROW_W'(gdcr_pkg::HALF_H) - half_lh[gdcr_pkg::ROW_W-1:0];
            draw_end   <= gdcr_pkg::ROW_W'(gdcr_pkg::HALF_H) + half_lh[gdcr_pkg::ROW_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/grid_dda_column_raycaster_unit.sv -----
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_unit: grid DDA wall-column raycaster
// Input items write the 64x64 wall map (mode 0) or cast one screen column
// (mode 1). A cast returns the clamped wall span, side, shade and edge flag.
// Input and output are valid/ready channels; the configuration port writes
// pos_x, pos_y, dir_x, dir_y, plane_x, plane_y (index 0..5); the user is to
// write them only while idle, which the block itself does not enforce.
// After reset the map is cleared with in_ready low; config writes are taken
// during that pass. A cast runs the shared one-bit-per-cycle divider for
// both reciprocals and the line height, each unless its denominator is zero,
// and each DDA step passes a stepping state and, unless it leaves the map,
// a map-read state. Casts are handled one at a time; a two-entry queue
// lets the input side keep taking items while the back end works. A stalled
// receiver holds the result register and the back end waits at the next
// result; the input keeps filling the queue.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [9:0]  column,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        wall,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  column_out,
  output logic [9:0]  draw_start,
  output logic [9:0]  draw_end,
  output logic        side,
  output logic [15:0] shade,
  output logic        edge_hit,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] plane_x;
  logic signed [15:0] plane_y;
  logic               clr_done;
  logic               push_valid;
  logic               push_ready;
  gdcr_pkg::item_t    push_item;
  logic               pop_valid;
  logic               pop_ready;
  gdcr_pkg::item_t    pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= gdcr_pkg::POS_X_RST;
      pos_y   <= gdcr_pkg::POS_Y_RST;
      dir_x   <= gdcr_pkg::DIR_X_RST;
      dir_y   <= gdcr_pkg::DIR_Y_RST;
      plane_x <= gdcr_pkg::PLANE_X_RST;
      plane_y <= gdcr_pkg::PLANE_Y_RST;
    end else if (cfg_we) begin
      case (gdcr_pkg::cfg_reg_t'(cfg_index))
        gdcr_pkg::CFG_POS_X:   pos_x   <= cfg_data;
        gdcr_pkg::CFG_POS_Y:   pos_y   <= cfg_data;
        gdcr_pkg::CFG_DIR_X:   dir_x   <= cfg_data;
        gdcr_pkg::CFG_DIR_Y:   dir_y   <= cfg_data;
        gdcr_pkg::CFG_PLANE_X: plane_x <= cfg_data;
        gdcr_pkg::CFG_PLANE_Y: plane_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gdcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (clr_done),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .column     (column),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .wall       (wall),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .plane_x    (plane_x),
    .plane_y    (plane_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  gdcr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  gdcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .clr_done   (clr_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .column_out (column_out),
    .draw_start (draw_start),
    .draw_end   (draw_end),
    .side       (side),
    .shade      (shade),
    .edge_hit   (edge_hit)
  );

endmodule

// ----- rtl/gdcr_checker.sv -----
// ----------------------------------------------------------------------------
// gdcr_checker: port-level checks for the raycaster
// Bound to the top level.
// ----------------------------------------------------------------------------
module gdcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  column_out,
  input logic [9:0]  draw_start,
  input logic [9:0]  draw_end,
  input logic        side,
  input logic [15:0] shade,
  input logic        edge_hit
);

  // map clear pass blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during map clear");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(column_out) && $stable(draw_start)
      && $stable(draw_end) && $stable(edge_hit))
    else $error("stalled result transfer changed");

  a_shade: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (side == 1'b0 && shade == gdcr_pkg::SHADE_X)
               || (side == 1'b1 && shade == gdcr_pkg::SHADE_Y))
    else $error("shade does not match side");

  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> draw_start <= draw_end && 32'(draw_end) < gdcr_pkg::SCREEN_H)
    else $error("wall span out of order or off screen");

endmodule

bind grid_dda_column_raycaster_unit gdcr_checker u_gdcr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .column_out (column_out),
  .draw_start (draw_start),
  .draw_end   (draw_end),
  .side       (side),
  .shade      (shade),
  .edge_hit   (edge_hit)
);
